### rtl/sdes_pkg.sv
// Shared types, constants and permutation functions for the S-DES byte cipher.
`timescale 1ns / 1ps
`default_nettype none

package sdes_pkg;

    localparam int KEY_W      = 10;
    localparam int SUBKEY_W   = 8;
    localparam int BLOCK_W    = 8;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W = 10;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CIPHER_KEY   = 1'b0,
        REG_DECRYPT_MODE = 1'b1
    } cfg_reg_t;

    // Subkeys in the order the two rounds use them.
    typedef struct packed {
        logic [SUBKEY_W-1:0] first;
        logic [SUBKEY_W-1:0] second;
    } subkeys_t;

    // S-boxes indexed by {row, column}, row = {b3, b0}, column = {b2, b1}.
    localparam logic [1:0] S0_ROM [0:15] = '{
        2'd1, 2'd0, 2'd3, 2'd2,
        2'd3, 2'd2, 2'd1, 2'd0,
        2'd0, 2'd2, 2'd1, 2'd3,
        2'd3, 2'd1, 2'd3, 2'd2
    };
    localparam logic [1:0] S1_ROM [0:15] = '{
        2'd0, 2'd1, 2'd2, 2'd3,
        2'd2, 2'd0, 2'd1, 2'd3,
        2'd3, 2'd0, 2'd1, 2'd0,
        2'd2, 2'd1, 2'd0, 2'd3
    };

    function automatic logic [9:0] p10(input logic [9:0] v);
        return {v[7], v[5], v[8], v[3], v[6], v[0], v[9], v[1], v[2], v[4]};
    endfunction

    function automatic logic [7:0] p8(input logic [9:0] v);
        return {v[4], v[7], v[3], v[6], v[2], v[5], v[0], v[1]};
    endfunction

    function automatic logic [7:0] ip(input logic [7:0] v);
        return {v[6], v[2], v[5], v[7], v[4], v[0], v[3], v[1]};
    endfunction

    function automatic logic [7:0] ip_inv(input logic [7:0] v);
        return {v[4], v[7], v[5], v[3], v[1], v[6], v[0], v[2]};
    endfunction

    function automatic logic [7:0] ep(input logic [3:0] v);
        return {v[0], v[3], v[2], v[1], v[2], v[1], v[0], v[3]};
    endfunction

    function automatic logic [3:0] p4(input logic [3:0] v);
        return {v[2], v[0], v[1], v[3]};
    endfunction

    function automatic logic [4:0] rot5_1(input logic [4:0] v);
        return {v[3:0], v[4]};
    endfunction

    function automatic logic [4:0] rot5_2(input logic [4:0] v);
        return {v[2:0], v[4:3]};
    endfunction

    function automatic logic [3:0] sbox_idx(input logic [3:0] n);
        return {n[3], n[0], n[2], n[1]};
    endfunction

endpackage

`default_nettype wire

### rtl/sdes_key_sched.sv
// Configuration registers and subkey generation for the S-DES byte cipher.
`timescale 1ns / 1ps
`default_nettype none

module sdes_key_sched (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [sdes_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [sdes_pkg::CFG_DATA_W-1:0]    cfg_data,
    output sdes_pkg::subkeys_t                      subkeys
);

    logic [sdes_pkg::KEY_W-1:0] key_reg;
    logic [sdes_pkg::KEY_W-1:0] key_next;
    logic                       decrypt_reg;
    logic                       decrypt_next;

    logic [9:0]                      key_p10;
    logic [4:0]                      hi1;
    logic [4:0]                      lo1;
    logic [sdes_pkg::SUBKEY_W-1:0]   k1;
    logic [sdes_pkg::SUBKEY_W-1:0]   k2;

    always_comb
    begin
        key_next     = key_reg;
        decrypt_next = decrypt_reg;
        if (cfg_we)
        begin
            case (sdes_pkg::cfg_reg_t'(cfg_index))
                sdes_pkg::REG_CIPHER_KEY:   key_next = cfg_data[sdes_pkg::KEY_W-1:0];
                sdes_pkg::REG_DECRYPT_MODE: decrypt_next = cfg_data[0];
                default:                    key_next = key_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg     <= '0;
            decrypt_reg <= 1'b0;
        end
        else
        begin
            key_reg     <= key_next;
            decrypt_reg <= decrypt_next;
        end
    end

    // The schedule is pure wiring, so the subkeys follow the key register directly.
    assign key_p10 = sdes_pkg::p10(key_reg);
    assign hi1     = sdes_pkg::rot5_1(key_p10[9:5]);
    assign lo1     = sdes_pkg::rot5_1(key_p10[4:0]);
    assign k1      = sdes_pkg::p8({hi1, lo1});
    assign k2      = sdes_pkg::p8({sdes_pkg::rot5_2(hi1), sdes_pkg::rot5_2(lo1)});

    assign subkeys.first  = decrypt_reg ? k2 : k1;
    assign subkeys.second = decrypt_reg ? k1 : k2;

endmodule

`default_nettype wire

### rtl/sdes_round.sv
// One Feistel round fk: left half xor F(right half, subkey), right half passed on.
`timescale 1ns / 1ps
`default_nettype none

module sdes_round (
    input  wire logic [sdes_pkg::BLOCK_W-1:0]  lr_in,
    input  wire logic [sdes_pkg::SUBKEY_W-1:0] subkey,
    output logic      [sdes_pkg::BLOCK_W-1:0]  lr_out
);

    logic [7:0] x;
    logic [1:0] s0_val;
    logic [1:0] s1_val;
    logic [3:0] f_val;

    assign x      = sdes_pkg::ep(lr_in[3:0]) ^ subkey;
    assign s0_val = sdes_pkg::S0_ROM[sdes_pkg::sbox_idx(x[7:4])];
    assign s1_val = sdes_pkg::S1_ROM[sdes_pkg::sbox_idx(x[3:0])];
    assign f_val  = sdes_pkg::p4({s0_val, s1_val});
    assign lr_out = {lr_in[7:4] ^ f_val, lr_in[3:0]};

endmodule

`default_nettype wire

### rtl/simplified_des_byte_cipher.sv
// S-DES byte cipher: three-stage pipeline, one item per cycle while the output is not stalled.
// An accepted input passes the stage 1, stage 2 and stage 3 registers on its way to the output.
// Throughput is one item per clock without a stall: stage 1 does IP and the first round,
// stage 2 the swap and second round, stage 3 registers the IP inverse result.
// A stall only holds stages that are full; empty stages keep filling.
// Reset clears all valid bits, the key to zero and the mode to encrypt.
`timescale 1ns / 1ps
`default_nettype none

module simplified_des_byte_cipher (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [sdes_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [sdes_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [sdes_pkg::BLOCK_W-1:0]       data_in,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic      [sdes_pkg::BLOCK_W-1:0]       data_out
);

    sdes_pkg::subkeys_t subkeys;

    logic                            v1_reg, v1_next;
    logic                            v2_reg, v2_next;
    logic                            v3_reg, v3_next;
    logic [sdes_pkg::BLOCK_W-1:0]    d1_reg, d1_next;
    logic [sdes_pkg::BLOCK_W-1:0]    d2_reg, d2_next;
    logic [sdes_pkg::BLOCK_W-1:0]    d3_reg, d3_next;

    logic                            ready1, ready2, ready3;
    logic [sdes_pkg::BLOCK_W-1:0]    round1_out;
    logic [sdes_pkg::BLOCK_W-1:0]    round2_out;

    sdes_key_sched u_key_sched (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .subkeys   (subkeys)
    );

    sdes_round u_round1 (
        .lr_in  (sdes_pkg::ip(data_in)),
        .subkey (subkeys.first),
        .lr_out (round1_out)
    );

    // The swap between the rounds exchanges the halves of the stage 1 result.
    sdes_round u_round2 (
        .lr_in  ({d1_reg[3:0], d1_reg[7:4]}),
        .subkey (subkeys.second),
        .lr_out (round2_out)
    );

    // A stage can load when it is empty or its content moves on this cycle.
    assign ready3 = !v3_reg || !out_stall;
    assign ready2 = !v2_reg || ready3;
    assign ready1 = !v1_reg || ready2;

    always_comb
    begin
        v1_next = v1_reg;
        d1_next = d1_reg;
        v2_next = v2_reg;
        d2_next = d2_reg;
        v3_next = v3_reg;
        d3_next = d3_reg;
        if (ready1)
        begin
            v1_next = in_valid;
            d1_next = round1_out;
        end
        if (ready2)
        begin
            v2_next = v1_reg;
            d2_next = round2_out;
        end
        if (ready3)
        begin
            v3_next = v2_reg;
            d3_next = sdes_pkg::ip_inv(d2_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d1_reg <= d1_next;
        d2_reg <= d2_next;
        d3_reg <= d3_next;
    end

    assign in_stall  = !ready1;
    assign out_valid = v3_reg;
    assign data_out  = d3_reg;

endmodule

`default_nettype wire

### rtl/sdes_checker.sv
// Port-level checks for the S-DES byte cipher, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module sdes_checker (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               in_valid,
    input wire logic                               in_stall,
    input wire logic                               out_valid,
    input wire logic                               out_stall,
    input wire logic [sdes_pkg::BLOCK_W-1:0]       data_out
);

    // A result that is held back stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output item dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(data_out))
        else $error("output item changed while stalled");

    // The input side is held off only when every stage is full behind a stalled output.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while the pipeline has room");

    // Free-running cycles with no new item drain the pipeline.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!in_valid && !out_stall) ##1 (!in_valid && !out_stall)
            ##1 (!in_valid && !out_stall) |=> !out_valid)
        else $error("pipeline did not drain");

endmodule

bind simplified_des_byte_cipher sdes_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .data_out  (data_out)
);

`default_nettype wire
